FILE: hw/rtl/swept_box_collision_time_macros.svh
// Assertion macros used by the swept box collision top level.
`ifndef SWEPT_BOX_COLLISION_TIME_MACROS_SVH
`define SWEPT_BOX_COLLISION_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sbct_pkg.sv
// Shared types and constants for the swept box collision pipeline.
`default_nettype none
package sbct_pkg;
  localparam int TIME_FRAC_BITS = 16;
  localparam int NAXES = 3;
  localparam int CW = 32;
  localparam int GW = CW + 1;
  localparam int QW = TIME_FRAC_BITS + 1;
  localparam int TW = TIME_FRAC_BITS + 2;
  localparam int FRONT_STAGES = 3;
  localparam int NV = FRONT_STAGES + QW;

  localparam logic [TW-1:0] T_CAP = {2'b10, {TIME_FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] T_ONE = {1'b1, {TIME_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    CFG_MOTION_X = 3'd0,
    CFG_MOTION_Y = 3'd1,
    CFG_MOTION_Z = 3'd2,
    CFG_GAP_TOL  = 3'd3,
    CFG_TIME_EPS = 3'd4
  } cfg_idx_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [GW-1:0] gap_t;
  typedef logic [GW-1:0] mag_t;
  typedef logic [CW-1:0] den_t;
  typedef logic [QW-1:0] quot_t;

  typedef struct packed {
    logic miss;
    logic active;
    logic ex_neg;
    logic ex_big;
  } lane_flags_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sbct_front.sv
// Front stages: gaps, magnitudes and per-axis qualification.
`default_nettype none
module sbct_front (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire sbct_pkg::coord_t       mlo [sbct_pkg::NAXES],
  input  wire sbct_pkg::coord_t       mhi [sbct_pkg::NAXES],
  input  wire sbct_pkg::coord_t       blo [sbct_pkg::NAXES],
  input  wire sbct_pkg::coord_t       bhi [sbct_pkg::NAXES],
  input  wire sbct_pkg::coord_t       motion [sbct_pkg::NAXES],
  input  wire sbct_pkg::den_t         den [sbct_pkg::NAXES],
  input  wire logic [11:0]            gap_tol,
  output sbct_pkg::lane_flags_t       flags_o [sbct_pkg::NAXES],
  output sbct_pkg::mag_t              num_ent_o [sbct_pkg::NAXES],
  output sbct_pkg::mag_t              num_ext_o [sbct_pkg::NAXES]
);
  sbct_pkg::gap_t        eg_nxt [sbct_pkg::NAXES];
  sbct_pkg::gap_t        xg_nxt [sbct_pkg::NAXES];
  logic                  ovl_nxt [sbct_pkg::NAXES];
  sbct_pkg::gap_t        s1_eg_r [sbct_pkg::NAXES];
  sbct_pkg::gap_t        s1_xg_r [sbct_pkg::NAXES];
  logic                  s1_mvz_r [sbct_pkg::NAXES];
  logic                  s1_mvn_r [sbct_pkg::NAXES];
  logic                  s1_ovl_r [sbct_pkg::NAXES];
  sbct_pkg::mag_t        s2_egm_r [sbct_pkg::NAXES];
  sbct_pkg::mag_t        s2_xgm_r [sbct_pkg::NAXES];
  logic                  s2_egn_r [sbct_pkg::NAXES];
  logic                  s2_xgn_r [sbct_pkg::NAXES];
  logic                  s2_mvz_r [sbct_pkg::NAXES];
  logic                  s2_mvn_r [sbct_pkg::NAXES];
  logic                  s2_ovl_r [sbct_pkg::NAXES];
  sbct_pkg::lane_flags_t flags_nxt [sbct_pkg::NAXES];
  sbct_pkg::mag_t        ent_nxt [sbct_pkg::NAXES];
  sbct_pkg::mag_t        ext_nxt [sbct_pkg::NAXES];
  sbct_pkg::lane_flags_t flags_r [sbct_pkg::NAXES];
  sbct_pkg::mag_t        ent_r [sbct_pkg::NAXES];
  sbct_pkg::mag_t        ext_r [sbct_pkg::NAXES];

  // Stage 1: entry and exit gaps by direction of motion.
  always_comb begin
    for (int i = 0; i < sbct_pkg::NAXES; i++) begin
      ovl_nxt[i] = (mhi[i] <= blo[i]) || (bhi[i] <= mlo[i]);
      if (motion[i][sbct_pkg::CW-1]) begin
        eg_nxt[i] = sbct_pkg::GW'(bhi[i]) - sbct_pkg::GW'(mlo[i]);
        xg_nxt[i] = sbct_pkg::GW'(blo[i]) - sbct_pkg::GW'(mhi[i]);
      end else begin
        eg_nxt[i] = sbct_pkg::GW'(blo[i]) - sbct_pkg::GW'(mhi[i]);
        xg_nxt[i] = sbct_pkg::GW'(bhi[i]) - sbct_pkg::GW'(mlo[i]);
      end
    end
  end

  // Stage 3: tolerance, direction and range checks.
  always_comb begin
    logic eg_zero;
    logic skip;
    for (int i = 0; i < sbct_pkg::NAXES; i++) begin
      eg_zero = (s2_egm_r[i] < sbct_pkg::GW'(gap_tol)) || (s2_egm_r[i] == '0);
      skip = !eg_zero && (s2_egn_r[i] != s2_mvn_r[i]);
      flags_nxt[i].active = !s2_mvz_r[i] && !skip;
      flags_nxt[i].miss = s2_mvz_r[i] ? s2_ovl_r[i]
                        : (!skip && !eg_zero && (s2_egm_r[i] > {1'b0, den[i]}));
      flags_nxt[i].ex_neg = (s2_xgm_r[i] != '0) && (s2_xgn_r[i] != s2_mvn_r[i]);
      flags_nxt[i].ex_big = s2_xgm_r[i] >= {den[i], 1'b0};
      ent_nxt[i] = (eg_zero || flags_nxt[i].miss) ? '0 : s2_egm_r[i];
      ext_nxt[i] = (flags_nxt[i].ex_neg || flags_nxt[i].ex_big) ? '0 : s2_xgm_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < sbct_pkg::NAXES; i++) begin
        s1_eg_r[i]  <= eg_nxt[i];
        s1_xg_r[i]  <= xg_nxt[i];
        s1_mvz_r[i] <= (motion[i] == '0);
        s1_mvn_r[i] <= motion[i][sbct_pkg::CW-1];
        s1_ovl_r[i] <= ovl_nxt[i];
        // Stage 2: magnitudes and signs.
        s2_egm_r[i] <= s1_eg_r[i][sbct_pkg::GW-1] ? (~$unsigned(s1_eg_r[i]) + sbct_pkg::GW'(1))
                                                  : $unsigned(s1_eg_r[i]);
        s2_xgm_r[i] <= s1_xg_r[i][sbct_pkg::GW-1] ? (~$unsigned(s1_xg_r[i]) + sbct_pkg::GW'(1))
                                                  : $unsigned(s1_xg_r[i]);
        s2_egn_r[i] <= s1_eg_r[i][sbct_pkg::GW-1];
        s2_xgn_r[i] <= s1_xg_r[i][sbct_pkg::GW-1];
        s2_mvz_r[i] <= s1_mvz_r[i];
        s2_mvn_r[i] <= s1_mvn_r[i];
        s2_ovl_r[i] <= s1_ovl_r[i];
        flags_r[i]  <= flags_nxt[i];
        ent_r[i]    <= ent_nxt[i];
        ext_r[i]    <= ext_nxt[i];
      end
    end
  end

  assign flags_o   = flags_r;
  assign num_ent_o = ent_r;
  assign num_ext_o = ext_r;
endmodule
`default_nettype wire

FILE: hw/rtl/sbct_div.sv
// Pipelined restoring divider pair for one axis, one quotient bit per stage.
`default_nettype none
module sbct_div (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire sbct_pkg::mag_t        num_ent_i,
  input  wire sbct_pkg::mag_t        num_ext_i,
  input  wire sbct_pkg::den_t        den_i,
  input  wire sbct_pkg::lane_flags_t flags_i,
  output sbct_pkg::quot_t            q_ent_o,
  output sbct_pkg::quot_t            q_ext_o,
  output sbct_pkg::lane_flags_t      flags_o
);
  sbct_pkg::den_t        rem_ent_r [sbct_pkg::QW];
  sbct_pkg::den_t        rem_ext_r [sbct_pkg::QW];
  sbct_pkg::quot_t       q_ent_r [sbct_pkg::QW];
  sbct_pkg::quot_t       q_ext_r [sbct_pkg::QW];
  sbct_pkg::lane_flags_t flags_r [sbct_pkg::QW];

  // Compare-subtract: returns {quotient bit, new remainder}.
  function automatic logic [sbct_pkg::GW-1:0] div_step(input sbct_pkg::mag_t t,
                                                       input sbct_pkg::den_t d);
    sbct_pkg::mag_t dd;
    sbct_pkg::mag_t diff;
    dd = {1'b0, d};
    diff = t - dd;
    if (t >= dd) begin
      return {1'b1, diff[sbct_pkg::CW-1:0]};
    end
    return {1'b0, t[sbct_pkg::CW-1:0]};
  endfunction

  for (genvar k = 0; k < sbct_pkg::QW; k++) begin : g_stage
    sbct_pkg::mag_t         t_ent;
    sbct_pkg::mag_t         t_ext;
    logic [sbct_pkg::GW-1:0] st_ent;
    logic [sbct_pkg::GW-1:0] st_ext;
    sbct_pkg::quot_t        q_ent_prev;
    sbct_pkg::quot_t        q_ext_prev;
    sbct_pkg::lane_flags_t  flags_prev;

    if (k == 0) begin : g_first
      // Integer bit: dividend is below twice the divisor.
      assign t_ent      = num_ent_i;
      assign t_ext      = num_ext_i;
      assign q_ent_prev = '0;
      assign q_ext_prev = '0;
      assign flags_prev = flags_i;
    end else begin : g_next
      assign t_ent      = {rem_ent_r[k-1], 1'b0};
      assign t_ext      = {rem_ext_r[k-1], 1'b0};
      assign q_ent_prev = q_ent_r[k-1];
      assign q_ext_prev = q_ext_r[k-1];
      assign flags_prev = flags_r[k-1];
    end

    assign st_ent = div_step(t_ent, den_i);
    assign st_ext = div_step(t_ext, den_i);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_ent_r[k] <= st_ent[sbct_pkg::CW-1:0];
        rem_ext_r[k] <= st_ext[sbct_pkg::CW-1:0];
        q_ent_r[k]   <= {q_ent_prev[sbct_pkg::QW-2:0], st_ent[sbct_pkg::CW]};
        q_ext_r[k]   <= {q_ext_prev[sbct_pkg::QW-2:0], st_ext[sbct_pkg::CW]};
        flags_r[k]   <= flags_prev;
      end
    end
  end

  assign q_ent_o = q_ent_r[sbct_pkg::QW-1];
  assign q_ext_o = q_ext_r[sbct_pkg::QW-1];
  assign flags_o = flags_r[sbct_pkg::QW-1];
endmodule
`default_nettype wire

FILE: hw/rtl/sbct_back.sv
// Back stages: pick latest entry and earliest exit, then decide the hit.
`default_nettype none
module sbct_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  valid_i,
  input  wire sbct_pkg::quot_t       q_ent [sbct_pkg::NAXES],
  input  wire sbct_pkg::quot_t       q_ext [sbct_pkg::NAXES],
  input  wire sbct_pkg::lane_flags_t flags [sbct_pkg::NAXES],
  input  wire logic [15:0]           time_eps,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [sbct_pkg::QW-1:0]    entry_time_o,
  output logic [1:0]                 normal_axis_o
);
  logic                      has_nxt;
  logic                      bad_nxt;
  sbct_pkg::quot_t           best_nxt;
  logic [1:0]                axis_nxt;
  logic [sbct_pkg::TW-1:0]   least_nxt;
  logic                      b1_valid_r;
  logic                      b1_has_r;
  logic                      b1_bad_r;
  sbct_pkg::quot_t           b1_best_r;
  logic [1:0]                b1_axis_r;
  logic [sbct_pkg::TW-1:0]   b1_least_r;
  logic                      hit_nxt;
  logic                      valid_r;
  logic                      hit_r;
  sbct_pkg::quot_t           time_r;
  logic [1:0]                axis_r;

  always_comb begin
    logic [sbct_pkg::TW-1:0] ext_v;
    has_nxt   = 1'b0;
    bad_nxt   = 1'b0;
    best_nxt  = '0;
    axis_nxt  = '0;
    least_nxt = sbct_pkg::T_CAP;
    for (int i = 0; i < sbct_pkg::NAXES; i++) begin
      ext_v = flags[i].ex_big ? sbct_pkg::T_CAP : {1'b0, q_ext[i]};
      if (flags[i].miss) begin
        bad_nxt = 1'b1;
      end
      if (flags[i].active) begin
        if (flags[i].ex_neg) begin
          bad_nxt = 1'b1;
        end
        // Ties keep the earlier axis.
        if (!has_nxt || (q_ent[i] > best_nxt)) begin
          best_nxt = q_ent[i];
          axis_nxt = 2'(i);
        end
        has_nxt = 1'b1;
        if (ext_v < least_nxt) begin
          least_nxt = ext_v;
        end
      end
    end
  end

  assign hit_nxt = !b1_bad_r && b1_has_r && ({1'b0, b1_best_r} <= b1_least_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (en) begin
      b1_valid_r <= valid_i;
      valid_r    <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_has_r   <= has_nxt;
      b1_bad_r   <= bad_nxt;
      b1_best_r  <= best_nxt;
      b1_axis_r  <= axis_nxt;
      b1_least_r <= least_nxt;
      hit_r      <= hit_nxt;
      // Drop near-zero entry times, and the time of a miss, to zero.
      time_r     <= (!hit_nxt || (b1_best_r < sbct_pkg::QW'(time_eps))) ? '0 : b1_best_r;
      axis_r     <= hit_nxt ? b1_axis_r : 2'd0;
    end
  end

  assign valid_o       = valid_r;
  assign hit_o         = hit_r;
  assign entry_time_o  = time_r;
  assign normal_axis_o = axis_r;
endmodule
`default_nettype wire

FILE: hw/rtl/swept_box_collision_time.sv
// Swept box collision time: one box pair per cycle while the output is not stalled,
// pipelined through 3 gap stages, 17 divider stages and 2 combine stages.
// The dividers are 17-stage restoring dividers, one quotient bit per stage.
// The whole pipeline advances together; it holds only while a result beat
// waits at the output under stall. Write configuration only when idle.
`default_nettype none
`include "swept_box_collision_time_macros.svh"
module swept_box_collision_time (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [31:0] in_mover_min_x,
  input  wire logic signed [31:0] in_mover_min_y,
  input  wire logic signed [31:0] in_mover_min_z,
  input  wire logic signed [31:0] in_mover_max_x,
  input  wire logic signed [31:0] in_mover_max_y,
  input  wire logic signed [31:0] in_mover_max_z,
  input  wire logic signed [31:0] in_block_min_x,
  input  wire logic signed [31:0] in_block_min_y,
  input  wire logic signed [31:0] in_block_min_z,
  input  wire logic signed [31:0] in_block_max_x,
  input  wire logic signed [31:0] in_block_max_y,
  input  wire logic signed [31:0] in_block_max_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic [16:0]      out_entry_time,
  output logic [1:0]       out_normal_axis
);
  sbct_pkg::coord_t      motion_r [sbct_pkg::NAXES];
  logic [11:0]           tol_r;
  logic [15:0]           eps_r;
  sbct_pkg::den_t        den [sbct_pkg::NAXES];
  sbct_pkg::coord_t      mlo [sbct_pkg::NAXES];
  sbct_pkg::coord_t      mhi [sbct_pkg::NAXES];
  sbct_pkg::coord_t      blo [sbct_pkg::NAXES];
  sbct_pkg::coord_t      bhi [sbct_pkg::NAXES];
  sbct_pkg::lane_flags_t f_flags [sbct_pkg::NAXES];
  sbct_pkg::mag_t        f_ent [sbct_pkg::NAXES];
  sbct_pkg::mag_t        f_ext [sbct_pkg::NAXES];
  sbct_pkg::quot_t       d_ent [sbct_pkg::NAXES];
  sbct_pkg::quot_t       d_ext [sbct_pkg::NAXES];
  sbct_pkg::lane_flags_t d_flags [sbct_pkg::NAXES];
  logic [sbct_pkg::NV-1:0] pipe_v_r;
  logic                  en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbct_pkg::NAXES; i++) begin
        motion_r[i] <= '0;
      end
      tol_r <= 12'd4;
      eps_r <= 16'd65;
    end else if (cfg_we) begin
      unique case (sbct_pkg::cfg_idx_t'(cfg_index))
        sbct_pkg::CFG_MOTION_X: motion_r[0] <= cfg_wdata;
        sbct_pkg::CFG_MOTION_Y: motion_r[1] <= cfg_wdata;
        sbct_pkg::CFG_MOTION_Z: motion_r[2] <= cfg_wdata;
        sbct_pkg::CFG_GAP_TOL:  tol_r <= cfg_wdata[11:0];
        sbct_pkg::CFG_TIME_EPS: eps_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= '0;
    end else if (en) begin
      pipe_v_r <= {pipe_v_r[sbct_pkg::NV-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < sbct_pkg::NAXES; i++) begin
      den[i] = motion_r[i][sbct_pkg::CW-1] ? (~$unsigned(motion_r[i]) + sbct_pkg::CW'(1))
                                           : $unsigned(motion_r[i]);
    end
  end

  assign mlo[0] = in_mover_min_x;
  assign mlo[1] = in_mover_min_y;
  assign mlo[2] = in_mover_min_z;
  assign mhi[0] = in_mover_max_x;
  assign mhi[1] = in_mover_max_y;
  assign mhi[2] = in_mover_max_z;
  assign blo[0] = in_block_min_x;
  assign blo[1] = in_block_min_y;
  assign blo[2] = in_block_min_z;
  assign bhi[0] = in_block_max_x;
  assign bhi[1] = in_block_max_y;
  assign bhi[2] = in_block_max_z;

  sbct_front u_front (
    .clk       (clk),
    .en        (en),
    .mlo       (mlo),
    .mhi       (mhi),
    .blo       (blo),
    .bhi       (bhi),
    .motion    (motion_r),
    .den       (den),
    .gap_tol   (tol_r),
    .flags_o   (f_flags),
    .num_ent_o (f_ent),
    .num_ext_o (f_ext)
  );

  for (genvar a = 0; a < sbct_pkg::NAXES; a++) begin : g_lane
    sbct_div u_div (
      .clk       (clk),
      .en        (en),
      .num_ent_i (f_ent[a]),
      .num_ext_i (f_ext[a]),
      .den_i     (den[a]),
      .flags_i   (f_flags[a]),
      .q_ent_o   (d_ent[a]),
      .q_ext_o   (d_ext[a]),
      .flags_o   (d_flags[a])
    );
  end

  sbct_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .valid_i       (pipe_v_r[sbct_pkg::NV-1]),
    .q_ent         (d_ent),
    .q_ext         (d_ext),
    .flags         (d_flags),
    .time_eps      (eps_r),
    .valid_o       (out_valid),
    .hit_o         (out_hit),
    .entry_time_o  (out_entry_time),
    .normal_axis_o (out_normal_axis)
  );

  `SBCT_ASSERT_NOW(a_hold_input, clk, rst_n, out_valid && out_stall, in_stall, "input taken while output beat stalled")
  `SBCT_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_hit, (out_entry_time == '0) && (out_normal_axis == 2'd0), "miss beat carries nonzero time or axis")
  `SBCT_ASSERT_NOW(a_time_range, clk, rst_n, out_valid && out_hit, (out_entry_time <= sbct_pkg::T_ONE) && (out_normal_axis != 2'd3), "hit beat time or axis out of range")
  `SBCT_ASSERT_NEXT(a_advance, clk, rst_n, !in_stall && pipe_v_r[sbct_pkg::NV-1], pipe_v_r[sbct_pkg::NV-1] == $past(pipe_v_r[sbct_pkg::NV-2]), "pipeline valid did not advance")
endmodule
`default_nettype wire
